### hw/rtl/tkst_pkg.sv
// Shared package for the k-smallest tracker: default parameters, action codes,
// FSM state type and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package tkst_pkg;

    localparam int K_MAX_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ACTION_W   = 2;
    localparam int CFG_W      = 5;
    localparam int HELD_CNT_W = 5;

    localparam logic [CFG_W-1:0] K_IN_USE_RST = CFG_W'(16);

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DRAIN  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_EMIT,
        ST_DRAIN_RD,
        ST_DRAIN_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;         // input transfer this cycle
        logic scan_rd;      // read slot r_idx for the max rescan
        logic drain_rd;     // read slot r_idx for drain
        logic load_status;  // load a status result into the output register
        logic load_elem;    // load a drained pair into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ins_replace;  // store full and incoming key beats the largest
        logic held_zero;
        logic idx_last;     // r_idx addresses the last held slot
        logic rd_last;      // pair in the read register is the last one
        logic out_free;     // output register can take a new result
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/tkst_ctrl.sv
// Controller FSM for the k-smallest tracker.
// Depends on tkst_pkg (state type, command/status structs, action codes).
`default_nettype none

module tkst_ctrl
    import tkst_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire [ACTION_W-1:0]  i_action,
    input  wire t_status        i_sts,
    output logic                o_in_stall,
    output t_cmd                o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_INSERT && i_sts.ins_replace) begin
                        n_state = ST_SCAN;
                    end else if (i_action == ACT_DRAIN && !i_sts.held_zero) begin
                        n_state = ST_DRAIN_RD;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.idx_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAIN_RD:  n_state = ST_DRAIN_OUT;
            ST_DRAIN_OUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.rd_last ? ST_IDLE : ST_DRAIN_RD;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            ST_SCAN:      o_cmd.scan_rd     = 1'b1;
            ST_EMIT:      o_cmd.load_status = i_sts.out_free;
            ST_DRAIN_RD:  o_cmd.drain_rd    = 1'b1;
            ST_DRAIN_OUT: o_cmd.load_elem   = i_sts.out_free;
            default:      o_cmd             = '0;
        endcase
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_status || o_cmd.load_elem) |-> i_sts.out_free)
        else $error("result loaded while output register busy");

    a_scan_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_END) |=> (r_state == ST_EMIT))
        else $error("rescan did not finish into result stage");

endmodule

`default_nettype wire

### hw/rtl/tkst_dpath.sv
// Datapath for the k-smallest tracker: pair storage, count, largest-slot
// tracking with a one-slot-per-cycle rescan, config register, output register.
// Depends on tkst_pkg (command/status structs, action codes, widths).
`default_nettype none

module tkst_dpath
    import tkst_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire [CFG_W-1:0]       i_cfg_wr_data,
    input  wire [ACTION_W-1:0]    i_action,
    input  wire [KEY_BITS-1:0]    i_key,
    input  wire [VALUE_BITS-1:0]  i_value,
    input  wire                   i_res_stall,
    input  wire t_cmd             i_cmd,
    output t_status               o_sts,
    output logic                  o_res_valid,
    output logic                  o_accepted,
    output logic [HELD_CNT_W-1:0] o_held_count,
    output logic [KEY_BITS-1:0]   o_max_insertable,
    output logic [KEY_BITS-1:0]   o_out_key,
    output logic [VALUE_BITS-1:0] o_out_value,
    output logic                  o_out_valid,
    output logic                  o_last
);

    localparam int SLOT_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CNT_W  = $clog2(K_MAX + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [KEY_BITS-1:0]   r_mem_key [K_MAX];
    logic [VALUE_BITS-1:0] r_mem_val [K_MAX];

    logic [CFG_W-1:0]      r_k_in_use;
    logic [CNT_W-1:0]      r_held;
    logic [SLOT_W-1:0]     r_largest;
    logic [KEY_BITS-1:0]   r_max_key;   // copy of the key at r_largest
    logic [CNT_W-1:0]      r_idx;
    logic                  r_acc;

    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [SLOT_W-1:0]     r_rd_slot;
    logic                  r_rd_last;
    logic                  r_cmp_vld;

    logic [CMP_W-1:0]      w_k_ext;
    logic [CMP_W-1:0]      w_eff_k;
    logic                  w_full;
    logic                  w_is_ins;
    logic                  w_replace;
    logic                  w_wr_en;
    logic [SLOT_W-1:0]     w_wr_slot;
    logic [SLOT_W-1:0]     w_idx_slot;
    logic [CNT_W-1:0]      w_idx_nxt;
    logic [KEY_BITS-1:0]   w_max_ins;

    // k_in_use of zero acts as one, above K_MAX it saturates
    always_comb begin
        w_k_ext = CMP_W'(r_k_in_use);
        if (w_k_ext == '0) begin
            w_eff_k = CMP_W'(1);
        end else if (w_k_ext > CMP_W'(K_MAX)) begin
            w_eff_k = CMP_W'(K_MAX);
        end else begin
            w_eff_k = w_k_ext;
        end
    end

    assign w_full     = CMP_W'(r_held) >= w_eff_k;
    assign w_is_ins   = (i_action == ACT_INSERT);
    assign w_replace  = w_full && (i_key < r_max_key);
    assign w_wr_en    = i_cmd.take && w_is_ins && (!w_full || w_replace);
    assign w_wr_slot  = w_full ? r_largest : r_held[SLOT_W-1:0];
    assign w_idx_slot = r_idx[SLOT_W-1:0];
    assign w_idx_nxt  = r_idx + CNT_W'(1);
    assign w_max_ins  = w_full ? r_max_key : '1;

    assign o_sts.ins_replace = w_replace;
    assign o_sts.held_zero   = (r_held == '0);
    assign o_sts.idx_last    = (w_idx_nxt == r_held);
    assign o_sts.rd_last     = r_rd_last;
    assign o_sts.out_free    = !o_res_valid || !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_in_use <= K_IN_USE_RST;
        end else if (i_cfg_wr_en) begin
            r_k_in_use <= i_cfg_wr_data;
        end
    end

    // pair storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_key[w_wr_slot] <= i_key;
            r_mem_val[w_wr_slot] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd || i_cmd.drain_rd) begin
            r_rd_key  <= r_mem_key[w_idx_slot];
            r_rd_val  <= r_mem_val[w_idx_slot];
            r_rd_slot <= w_idx_slot;
            r_rd_last <= (w_idx_nxt == r_held);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_idx <= '0;
        end else if (i_cmd.scan_rd || i_cmd.drain_rd) begin
            r_idx <= w_idx_nxt;
        end
    end

    // count, largest slot and its key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_largest <= '0;
        end else if (i_cmd.take) begin
            r_acc <= 1'b0;
            if (w_is_ins) begin
                if (!w_full) begin
                    r_acc  <= 1'b1;
                    r_held <= r_held + CNT_W'(1);
                    if (r_held == '0 || i_key > r_max_key) begin
                        r_largest <= r_held[SLOT_W-1:0];
                        r_max_key <= i_key;
                    end
                end else if (w_replace) begin
                    // replaced slot is the starting candidate of the rescan
                    r_acc     <= 1'b1;
                    r_max_key <= i_key;
                end
            end else if (i_action == ACT_CLEAR) begin
                r_held    <= '0;
                r_largest <= '0;
            end
        end else if (r_cmp_vld && (r_rd_key > r_max_key)) begin
            // strict compare: ties keep the earlier candidate
            r_largest <= r_rd_slot;
            r_max_key <= r_rd_key;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (i_cmd.load_status || i_cmd.load_elem) begin
            o_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            o_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_status) begin
            o_accepted       <= r_acc;
            o_held_count     <= HELD_CNT_W'(r_held);
            o_max_insertable <= w_max_ins;
            o_out_key        <= '0;
            o_out_value      <= '0;
            o_out_valid      <= 1'b0;
            o_last           <= 1'b1;
        end else if (i_cmd.load_elem) begin
            o_accepted       <= 1'b0;
            o_held_count     <= HELD_CNT_W'(r_held);
            o_max_insertable <= w_max_ins;
            o_out_key        <= r_rd_key;
            o_out_value      <= r_rd_val;
            o_out_valid      <= 1'b1;
            o_last           <= r_rd_last;
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(K_MAX))
        else $error("held count above capacity");

    a_largest_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != '0) |-> (CNT_W'(r_largest) < r_held))
        else $error("largest slot outside held pairs");

    a_no_take_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> !r_cmp_vld)
        else $error("new item taken while rescan compare pending");

endmodule

`default_nettype wire

### hw/rtl/top_k_smallest_tracker_top.sv
// K-smallest tracker top level: insert/drain/clear one item at a time.
// Insert while filling, rejected insert, clear, other code and drain of an empty
// store go straight to the status result. An insert that replaces first rescans
// the held pairs, one slot per cycle, through the storage read port.
// Drain reads and emits each held pair in turn. Output stall holds the result.
// Reset (synchronous, active low): count and largest slot to zero, k_in_use 16.
// Pair storage is not cleared.
`default_nettype none

module top_k_smallest_tracker_top
    import tkst_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire [CFG_W-1:0]       i_cfg_wr_data,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire [ACTION_W-1:0]    i_action,
    input  wire [KEY_BITS-1:0]    i_key,
    input  wire [VALUE_BITS-1:0]  i_value,
    output logic                  o_res_valid,
    input  wire                   i_res_stall,
    output logic                  o_accepted,
    output logic [HELD_CNT_W-1:0] o_held_count,
    output logic [KEY_BITS-1:0]   o_max_insertable,
    output logic [KEY_BITS-1:0]   o_out_key,
    output logic [VALUE_BITS-1:0] o_out_value,
    output logic                  o_out_valid,
    output logic                  o_last
);

    t_cmd    w_cmd;
    t_status w_sts;

    tkst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    tkst_dpath #(
        .K_MAX      (K_MAX),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_action         (i_action),
        .i_key            (i_key),
        .i_value          (i_value),
        .i_res_stall      (i_res_stall),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_res_valid      (o_res_valid),
        .o_accepted       (o_accepted),
        .o_held_count     (o_held_count),
        .o_max_insertable (o_max_insertable),
        .o_out_key        (o_out_key),
        .o_out_value      (o_out_value),
        .o_out_valid      (o_out_valid),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire
